>>> rtl/cbtd_pkg.sv
// Package for the change bitmap tree decoder: types, constants and the
// set-bit search used by the front end.
// No dependencies.
`default_nettype none

package cbtd_pkg;

    // Number of two-line blocks covered by the header bitmap (1..32).
    localparam int BLOCKS = 26;

    // Header bits at and above BLOCKS are cleared.
    localparam logic [31:0] KEEP_MASK = 32'((64'd1 << BLOCKS) - 64'd1);
    localparam logic [5:0]  BLOCK_LIMIT = 6'(BLOCKS);

    localparam logic [6:0] LINE_COUNT_RESET = 7'd51;

    // What the next non-start byte is expected to be.
    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_SEGMASK,
        KIND_PAIRMASK,
        KIND_VALUE
    } kind_t;

    // One classified beat as it travels from the front end to the back end.
    typedef struct packed {
        logic       is_value;
        logic       done;
        logic       stray;
        logic [5:0] x;
        logic [5:0] y;
        logic [7:0] data;
    } rec_t;

    // Result of a set-bit search.
    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } hit_t;

    // Lowest set bit of v at a position in [from, limit).
    function automatic hit_t lowest_set(input logic [31:0] v, input logic [5:0] from,
                                        input logic [5:0] limit);
        hit_t h;
        h = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i] && (6'(i) >= from) && (6'(i) < limit)) begin
                h.found = 1'b1;
                h.idx   = 5'(i);
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cbtd_front.sv
// Front end of the change bitmap tree decoder: tree walk state and per-byte
// classification. Depends on cbtd_pkg.
`default_nettype none

module cbtd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_start,
    output cbtd_pkg::rec_t     out_rec
);

    cbtd_pkg::kind_t kind_reg, kind_next;
    logic [2:0]  hc_reg, hc_next;
    logic [31:0] bitmap_reg, bitmap_next;
    logic [4:0]  block_idx_reg, block_idx_next;
    logic [7:0]  seg_mask_reg, seg_mask_next;
    logic [2:0]  seg_idx_reg, seg_idx_next;
    logic [7:0]  pair_mask_reg, pair_mask_next;
    logic [2:0]  pair_idx_reg, pair_idx_next;
    logic        half_reg, half_next;

    logic        header_end;
    logic [31:0] hdr_bitmap;
    logic [31:0] block_src;
    logic [5:0]  block_from;
    logic [7:0]  seg_src, pair_src;
    logic [5:0]  seg_from, pair_from;
    cbtd_pkg::hit_t bh, sh, ph;
    logic        do_pair, do_seg, do_block;
    logic        walk_done;

    // Candidate searches at all three levels, resolved by priority below.
    always_comb begin
        hdr_bitmap = bitmap_reg | (32'(in_byte) << {hc_reg[1:0], 3'b000});
        header_end = !in_start && (kind_reg == cbtd_pkg::KIND_IDLE) && (hc_reg == 3'd3);
        block_src  = header_end ? (hdr_bitmap & cbtd_pkg::KEEP_MASK) : bitmap_reg;
        block_from = header_end ? 6'd0 : (6'(block_idx_reg) + 6'd1);
        seg_src    = (kind_reg == cbtd_pkg::KIND_SEGMASK) ? in_byte : seg_mask_reg;
        seg_from   = (kind_reg == cbtd_pkg::KIND_SEGMASK) ? 6'd0 : (6'(seg_idx_reg) + 6'd1);
        pair_src   = (kind_reg == cbtd_pkg::KIND_PAIRMASK) ? in_byte : pair_mask_reg;
        pair_from  = (kind_reg == cbtd_pkg::KIND_PAIRMASK) ? 6'd0 : (6'(pair_idx_reg) + 6'd1);
        bh = cbtd_pkg::lowest_set(block_src, block_from, cbtd_pkg::BLOCK_LIMIT);
        sh = cbtd_pkg::lowest_set({24'd0, seg_src}, seg_from, 6'd8);
        ph = cbtd_pkg::lowest_set({24'd0, pair_src}, pair_from, 6'd8);
    end

    // Next state
    always_comb begin
        kind_next      = kind_reg;
        hc_next        = hc_reg;
        bitmap_next    = bitmap_reg;
        block_idx_next = block_idx_reg;
        seg_mask_next  = seg_mask_reg;
        seg_idx_next   = seg_idx_reg;
        pair_mask_next = pair_mask_reg;
        pair_idx_next  = pair_idx_reg;
        half_next      = half_reg;
        do_pair        = 1'b0;
        do_seg         = 1'b0;
        do_block       = 1'b0;
        walk_done      = 1'b0;

        if (in_start) begin
            bitmap_next = 32'(in_byte);
            hc_next     = 3'd1;
            kind_next   = cbtd_pkg::KIND_IDLE;
        end else begin
            case (kind_reg)
                cbtd_pkg::KIND_IDLE: begin
                    if (hc_reg inside {[3'd1:3'd3]}) begin
                        if (header_end) begin
                            bitmap_next = block_src;
                            hc_next     = 3'd0;
                            do_block    = 1'b1;
                        end else begin
                            bitmap_next = hdr_bitmap;
                            hc_next     = hc_reg + 3'd1;
                        end
                    end else begin
                        hc_next = 3'd0;
                    end
                end
                cbtd_pkg::KIND_SEGMASK: begin
                    seg_mask_next = in_byte;
                    do_seg        = 1'b1;
                end
                cbtd_pkg::KIND_PAIRMASK: begin
                    pair_mask_next = in_byte;
                    do_pair        = 1'b1;
                end
                cbtd_pkg::KIND_VALUE: begin
                    if (!half_reg) begin
                        half_next = 1'b1;
                    end else begin
                        do_pair = 1'b1;
                    end
                end
                default: begin
                    kind_next = cbtd_pkg::KIND_IDLE;
                end
            endcase

            // Seek cascade: pair, then segment, then block, then frame end.
            if (do_pair && ph.found) begin
                pair_idx_next = ph.idx[2:0];
                half_next     = 1'b0;
                kind_next     = cbtd_pkg::KIND_VALUE;
            end else if ((do_pair || do_seg) && sh.found) begin
                seg_idx_next = sh.idx[2:0];
                kind_next    = cbtd_pkg::KIND_PAIRMASK;
            end else if ((do_pair || do_seg || do_block) && bh.found) begin
                block_idx_next = bh.idx;
                kind_next      = cbtd_pkg::KIND_SEGMASK;
            end else if (do_pair || do_seg || do_block) begin
                kind_next = cbtd_pkg::KIND_IDLE;
                hc_next   = 3'd0;
                walk_done = 1'b1;
            end
        end
    end

    // Outputs: classification of the current beat
    always_comb begin
        out_rec          = '0;
        out_rec.data     = in_byte;
        out_rec.is_value = !in_start && (kind_reg == cbtd_pkg::KIND_VALUE);
        out_rec.stray    = !in_start && (kind_reg == cbtd_pkg::KIND_IDLE)
                           && !(hc_reg inside {[3'd1:3'd3]});
        out_rec.done     = walk_done;
        out_rec.x        = {seg_idx_reg[1:0], pair_idx_reg, half_reg};
        out_rec.y        = {block_idx_reg, seg_idx_reg[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= cbtd_pkg::KIND_IDLE;
            hc_reg        <= 3'd0;
            bitmap_reg    <= 32'd0;
            block_idx_reg <= 5'd0;
            seg_mask_reg  <= 8'd0;
            seg_idx_reg   <= 3'd0;
            pair_mask_reg <= 8'd0;
            pair_idx_reg  <= 3'd0;
            half_reg      <= 1'b0;
        end else if (in_accept) begin
            kind_reg      <= kind_next;
            hc_reg        <= hc_next;
            bitmap_reg    <= bitmap_next;
            block_idx_reg <= block_idx_next;
            seg_mask_reg  <= seg_mask_next;
            seg_idx_reg   <= seg_idx_next;
            pair_mask_reg <= pair_mask_next;
            pair_idx_reg  <= pair_idx_next;
            half_reg      <= half_next;
        end
    end

`ifndef SYNTHESIS
    // Header counting only happens while no tree level is expected.
    a_hc_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (kind_reg != cbtd_pkg::KIND_IDLE) |-> (hc_reg == 3'd0))
        else $error("header count nonzero during tree walk");
    // Header count never reaches four between beats.
    a_hc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hc_reg <= 3'd3)
        else $error("header count out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/cbtd_queue.sv
// Two-entry queue of classified beats between the decoder front and back ends.
// Depends on cbtd_pkg.
`default_nettype none

module cbtd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire cbtd_pkg::rec_t push_rec,
    output logic               full,
    input  wire logic          pop,
    output cbtd_pkg::rec_t     pop_rec,
    output logic               not_empty
);

    cbtd_pkg::rec_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_rec   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue count out of range");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && full) |-> pop)
        else $error("queue push while full");
`endif

endmodule

`default_nettype wire

>>> rtl/cbtd_back.sv
// Back end of the change bitmap tree decoder: line clipping and the result
// output register. Depends on cbtd_pkg.
`default_nettype none

module cbtd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [6:0]    line_count,
    input  wire logic          q_valid,
    input  wire cbtd_pkg::rec_t q_rec,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    logic        valid_reg;
    logic [23:0] data_reg, data_next;
    logic [1:0]  user_reg, user_next;
    logic        last_reg;
    logic        wv;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb begin
        wv        = q_rec.is_value && ({1'b0, q_rec.y} < line_count);
        data_next = wv ? {4'd0, q_rec.data, q_rec.y, q_rec.x} : 24'd0;
        user_next = {q_rec.stray, wv};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= data_next;
            user_reg <= user_next;
            last_reg <= q_rec.done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> rtl/change_bitmap_tree_decoder_unit.sv
// Top level of the change bitmap tree decoder: line_count register and the
// front end, queue and back end. Depends on cbtd_pkg, cbtd_front, cbtd_queue, cbtd_back.
`default_nettype none

// Decodes a packed change-bitmap frame one byte per beat and gives exactly one
// result beat per input beat. A frame is a 4-byte block bitmap (low byte
// first, flagged by s_tuser on its first byte), then a segment mask per set
// block, a pair mask per set segment and two value bytes per set pair. Each
// value byte is reported as a pixel write unless its line is at or above
// line_count. Throughput is one beat per clock while the queue has room and
// the output is not stalled: the whole tree walk step, including the three-level
// next-set-bit search, is done in the cycle the byte is accepted. Each beat
// goes from the front end into the two-entry queue, then the output register.
// line_count may only be written while no beat is in flight.
module change_bitmap_tree_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,   // line_count
    // byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] packed_byte
    input  wire logic        s_tuser,       // [0] frame_start
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,       // [5:0] pixel_x, [11:6] pixel_y, [19:12] pixel_value
    output logic [1:0]       m_tuser,       // [0] write_valid, [1] stray_byte
    output logic             m_tlast        // frame_done
);

    logic [6:0] line_count_reg;

    logic           in_accept;
    cbtd_pkg::rec_t front_rec;
    cbtd_pkg::rec_t q_rec;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= cbtd_pkg::LINE_COUNT_RESET;
        end else if (cfg_wr_en) begin
            line_count_reg <= cfg_wr_data;
        end
    end

    // Input is taken whenever the queue has room; the queue drains into the
    // output register whenever that register is empty or its beat is taken.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    cbtd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .out_rec   (front_rec)
    );

    cbtd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_rec  (front_rec),
        .full      (q_full),
        .pop       (q_pop),
        .pop_rec   (q_rec),
        .not_empty (q_valid)
    );

    cbtd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_count (line_count_reg),
        .q_valid    (q_valid),
        .q_rec      (q_rec),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTHESIS
    // Pixel fields are zero on any beat that is not a write.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 24'd0))
        else $error("nonzero pixel fields without write");
    // A stray byte never ends a frame and is never a write.
    a_stray_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (!m_tlast && !m_tuser[0]))
        else $error("stray byte flagged with write or frame end");
`endif

endmodule

`default_nettype wire

>>> tb/sv/cbtd_decode_checker.sv
`timescale 1ns / 1ps
// Scoreboard for change_bitmap_tree_decoder_unit: follows line_count writes and
// the byte and result beats, walks the bitmap tree itself and compares results.
// Depends on cbtd_pkg.
module cbtd_decode_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] packed_byte
    input  wire logic        s_tuser,     // [0] frame_start
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,     // [5:0] pixel_x, [11:6] pixel_y, [19:12] pixel_value
    input  wire logic [1:0]  m_tuser,     // [0] write_valid, [1] stray_byte
    input  wire logic        m_tlast,     // frame_done
    output int               fail_count,
    output int               pending
);

    typedef struct {
        logic       wv;
        logic [5:0] x;
        logic [5:0] y;
        logic [7:0] val;
        logic       done;
        logic       stray;
    } decode_res_t;

    decode_res_t decoded_q[$];
    int          err_cnt = 0;
    int          outstanding = 0;

    assign fail_count = err_cnt;
    assign pending    = outstanding;

    // Tree walk position
    logic [6:0]  lines;
    logic [2:0]  hdr_cnt;
    logic [31:0] bmap;
    logic [4:0]  cur_blk;
    logic [7:0]  seg_bits;
    logic [2:0]  cur_seg;
    logic [7:0]  pair_bits;
    logic [2:0]  cur_pair;
    logic        second_half;
    cbtd_pkg::kind_t next_kind;

    function automatic int first_one(input logic [31:0] v, input int from, input int lim);
        for (int i = from; i < lim && i < 32; i++)
            if (v[i]) return i;
        return -1;
    endfunction

    task automatic goto_block(input int from, output bit fin);
        int b;
        b = first_one(bmap, from, cbtd_pkg::BLOCKS);
        fin = (b < 0);
        if (fin) begin
            next_kind = cbtd_pkg::KIND_IDLE;
            hdr_cnt   = '0;
        end else begin
            cur_blk   = b[4:0];
            next_kind = cbtd_pkg::KIND_SEGMASK;
        end
    endtask

    task automatic goto_segment(input int from, output bit fin);
        int s;
        s = first_one({24'd0, seg_bits}, from, 8);
        if (s < 0) begin
            goto_block(int'(cur_blk) + 1, fin);
        end else begin
            cur_seg   = s[2:0];
            next_kind = cbtd_pkg::KIND_PAIRMASK;
            fin       = 1'b0;
        end
    endtask

    task automatic goto_pair(input int from, output bit fin);
        int p;
        p = first_one({24'd0, pair_bits}, from, 8);
        if (p < 0) begin
            goto_segment(int'(cur_seg) + 1, fin);
        end else begin
            cur_pair    = p[2:0];
            second_half = 1'b0;
            next_kind   = cbtd_pkg::KIND_VALUE;
            fin         = 1'b0;
        end
    endtask

    task automatic decode_byte(input logic [7:0] byt, input logic st, output decode_res_t r);
        bit         fin;
        logic [5:0] px;
        logic [5:0] py;
        r   = '{default: '0};
        fin = 1'b0;
        if (st) begin
            bmap      = {24'd0, byt};
            hdr_cnt   = 3'd1;
            next_kind = cbtd_pkg::KIND_IDLE;
        end else begin
            case (next_kind)
                cbtd_pkg::KIND_IDLE: begin
                    if (hdr_cnt >= 3'd1 && hdr_cnt <= 3'd3) begin
                        bmap    = bmap | ({24'd0, byt} << (8 * hdr_cnt));
                        hdr_cnt = hdr_cnt + 3'd1;
                        if (hdr_cnt == 3'd4) begin
                            for (int i = cbtd_pkg::BLOCKS; i < 32; i++) bmap[i] = 1'b0;
                            hdr_cnt = '0;
                            goto_block(0, fin);
                        end
                    end else begin
                        hdr_cnt = '0;
                        r.stray = 1'b1;
                    end
                end
                cbtd_pkg::KIND_SEGMASK: begin
                    seg_bits = byt;
                    goto_segment(0, fin);
                end
                cbtd_pkg::KIND_PAIRMASK: begin
                    pair_bits = byt;
                    goto_pair(0, fin);
                end
                default: begin
                    px = {cur_seg[1:0], cur_pair, second_half};
                    py = {cur_blk, cur_seg[2]};
                    if ({1'b0, py} < lines) begin
                        r.wv  = 1'b1;
                        r.x   = px;
                        r.y   = py;
                        r.val = byt;
                    end
                    if (!second_half) second_half = 1'b1;
                    else goto_pair(int'(cur_pair) + 1, fin);
                end
            endcase
        end
        r.done = fin;
    endtask

    function automatic int field_bad(input string name, input logic [7:0] e,
                                     input logic [7:0] a);
        if (a !== e) begin
            $error("%s expected %0d got %0d", name, e, a);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        decode_res_t want_r;
        decode_res_t got;
        int          bad;
        bad = 0;
        if (!aresetn) begin
            lines       = cbtd_pkg::LINE_COUNT_RESET;
            hdr_cnt     = '0;
            bmap        = '0;
            cur_blk     = '0;
            seg_bits    = '0;
            cur_seg     = '0;
            pair_bits   = '0;
            cur_pair    = '0;
            second_half = 1'b0;
            next_kind   = cbtd_pkg::KIND_IDLE;
            decoded_q.delete();
        end else begin
            if (cfg_wr_en) lines = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser, want_r);
                decoded_q.push_back(want_r);
            end
            if (m_tvalid && m_tready) begin
                got.wv    = m_tuser[0];
                got.stray = m_tuser[1];
                got.x     = m_tdata[5:0];
                got.y     = m_tdata[11:6];
                got.val   = m_tdata[19:12];
                got.done  = m_tlast;
                if (decoded_q.size() == 0) begin
                    $error("result beat with no byte outstanding");
                    bad++;
                end else begin
                    want_r = decoded_q.pop_front();
                    bad += field_bad("write_valid", 8'(want_r.wv), 8'(got.wv));
                    bad += field_bad("pixel_x", 8'(want_r.x), 8'(got.x));
                    bad += field_bad("pixel_y", 8'(want_r.y), 8'(got.y));
                    bad += field_bad("pixel_value", want_r.val, got.val);
                    bad += field_bad("frame_done", 8'(want_r.done), 8'(got.done));
                    bad += field_bad("stray_byte", 8'(want_r.stray), 8'(got.stray));
                end
            end
        end
        err_cnt     <= err_cnt + bad;
        outstanding <= decoded_q.size();
    end

endmodule

>>> tb/sv/change_bitmap_tree_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for change_bitmap_tree_decoder_unit: clock, reset, frame stimulus,
// line_count phases and the verdict. Depends on cbtd_pkg and cbtd_decode_checker.
module change_bitmap_tree_decoder_unit_tb;

    // no beat on either side for this long means the DUT is stuck
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 270;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] packed_byte
    logic        s_tuser = 1'b0;    // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [5:0] pixel_x, [11:6] pixel_y, [19:12] pixel_value
    logic [1:0]  m_tuser;           // [0] write_valid, [1] stray_byte
    logic        m_tlast;           // frame_done

    int fail_count;
    int pending;

    // one stream byte plus its frame_start flag
    typedef struct packed {
        logic       st;
        logic [7:0] b;
    } stim_beat_t;

    stim_beat_t stim_q[$];

    bit quiet = 1'b0;       // final phase: no gaps, no backpressure
    int src_calm = 0;       // beats left in a gap-free stretch on the input
    int snk_hold = 0;       // cycles left with m_tready low
    int snk_calm = 0;       // cycles left in a stall-free stretch on the output
    int idle_cyc = 0;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    change_bitmap_tree_decoder_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    cbtd_decode_checker u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Output backpressure: random stall bursts broken up by stall-free stretches.
    // Nothing once the final phase begins.
    always @(posedge aclk) begin
        if (snk_hold > 0) begin
            snk_hold--;
        end else if (!quiet && snk_calm == 0 && $urandom_range(0, 5) == 0) begin
            snk_hold = $urandom_range(1, 14);
        end else if (snk_calm > 0) begin
            snk_calm--;
        end else if ($urandom_range(0, 49) == 0) begin
            snk_calm = $urandom_range(20, 200);
        end
        m_tready <= (snk_hold == 0);
    end

    // Watchdog: restarts on any beat, in or out.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    function automatic void put(input logic st, input logic [7:0] b);
        stim_q.push_back('{st: st, b: b});
    endfunction

    // Mostly sparse masks so frames stay short; empty and full masks show up too.
    function automatic logic [7:0] rand_mask();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'($urandom);
            default: return 8'(1 << $urandom_range(0, 7)) | 8'($urandom & $urandom & $urandom);
        endcase
    endfunction

    // Builds one well-formed frame with random content. When cut is set only a
    // prefix goes out, so the next frame_start lands mid-frame.
    task automatic add_frame(input bit cut);
        stim_beat_t  f[$];
        logic [31:0] hdr;
        logic [7:0]  sm;
        logic [7:0]  pm;
        int          n;
        if ($urandom_range(0, 11) == 0) begin
            hdr = $urandom;
        end else begin
            // a few blocks; bits at and above BLOCKS are ignored by the DUT
            hdr = '0;
            n = $urandom_range(0, 4);
            repeat (n) hdr[$urandom_range(0, 31)] = 1'b1;
        end
        for (int i = 0; i < 4; i++) f.push_back('{st: (i == 0), b: hdr[8*i +: 8]});
        for (int blk = 0; blk < cbtd_pkg::BLOCKS; blk++) begin
            if (hdr[blk]) begin
                sm = rand_mask();
                f.push_back('{st: 1'b0, b: sm});
                for (int j = 0; j < 8; j++) begin
                    if (sm[j]) begin
                        pm = rand_mask();
                        f.push_back('{st: 1'b0, b: pm});
                        for (int k = 0; k < 8; k++)
                            if (pm[k]) repeat (2) f.push_back('{st: 1'b0, b: 8'($urandom)});
                    end
                end
            end
        end
        n = (cut && f.size() > 1) ? $urandom_range(1, f.size() - 1) : f.size();
        for (int i = 0; i < n; i++) stim_q.push_back(f[i]);
    endtask

    // Fills one phase: mostly whole frames, some cut frames, stray bytes and
    // bytes with random frame_start.
    task automatic plan_phase(input int count);
        int r;
        while (stim_q.size() < count) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                add_frame(1'b0);
            end else if (r < 88) begin
                add_frame(1'b1);
            end else if (r < 94) begin
                repeat ($urandom_range(1, 3)) put(1'b0, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) put($urandom_range(0, 3) == 0, 8'($urandom));
            end
        end
    endtask

    // Sends the queued bytes. Random gaps on the input come in bursts except
    // during gap-free stretches and in the final phase.
    task automatic send_all();
        stim_beat_t it;
        while (stim_q.size() > 0) begin
            it = stim_q.pop_front();
            if (src_calm > 0) begin
                src_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                src_calm = $urandom_range(10, 80);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.b;
            s_tuser  <= it.st;
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;
    endtask

    // line_count is only written with nothing in flight: the task waits until no
    // result is pending and then leaves spare cycles before the write.
    task automatic write_line_count(input logic [6:0] v);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int lc[6];
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, line_count at its reset value of 51.
        // byte while idle without frame_start: stray
        put(1'b0, 8'hFF);
        // only bitmap bits at and above BLOCKS: cleared, frame done on the last header byte
        put(1'b1, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'hFC);
        // restart in the middle of a header
        put(1'b1, 8'h03);
        put(1'b0, 8'h11);
        // blocks 0 and 25: corner pixels, line 50 written, line 51 dropped
        put(1'b1, 8'h01);
        put(1'b0, 8'h00);
        put(1'b0, 8'h00);
        put(1'b0, 8'h02);
        put(1'b0, 8'h01);   // block 0: segment 0
        put(1'b0, 8'h01);   // pair 0 -> pixels 0,1 of line 0
        put(1'b0, 8'h00);
        put(1'b0, 8'hFF);
        put(1'b0, 8'h88);   // block 25: segments 3 and 7
        put(1'b0, 8'h80);   // pair 7 -> pixels 62,63 of line 50
        put(1'b0, 8'hA5);
        put(1'b0, 8'h5A);
        put(1'b0, 8'h01);   // segment 7, line 51: dropped at 51
        put(1'b0, 8'h55);
        put(1'b0, 8'hAA);   // ends the frame
        send_all();

        // Random phases over several line_count settings, extremes first.
        lc = '{64, 1, 0, 127, $urandom_range(2, 63), 51};
        foreach (lc[i]) begin
            if (i == 5) quiet = 1'b1;
            write_line_count(7'(lc[i]));
            plan_phase(PHASE_BEATS);
            send_all();
        end

        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/cbtd_pkg.sv
rtl/cbtd_front.sv
rtl/cbtd_queue.sv
rtl/cbtd_back.sv
rtl/change_bitmap_tree_decoder_unit.sv
tb/sv/cbtd_decode_checker.sv
tb/sv/change_bitmap_tree_decoder_unit_tb.sv
